// ===== src/spsc_pkg.sv =====
// Shared types and constants for the sorted priority stack.
`timescale 1ns / 1ps
`default_nettype none
package spsc_pkg;

  localparam int DEPTH  = 16;
  localparam int ELEM_W = 32;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int IN_TDATA_W  = ((ELEM_W + PRIO_W + 7) / 8) * 8;
  localparam int RES_W       = ELEM_W + PRIO_W + CNT_W + 1 + 2;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Lowest bits first: top_element, top_priority, count, is_empty, error.
  typedef struct packed {
    err_e              error;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
    logic [PRIO_W-1:0] top_priority;
    logic [ELEM_W-1:0] top_element;
  } res_t;

endpackage
`default_nettype wire

// ===== src/sorted_priority_stack_core.sv =====
// Top level of the sorted priority stack: input register, store and result register.
//
//  channel   dir  tuser       tdata (low bit first)
//  s_axis    in   op          element[31:0], priority_req[39:32]
//  m_axis    out  -           top_element, top_priority, count, is_empty, error
//
//  One transfer per cycle unless m_axis stalls; a result passes input then result register.
//  All cells compare against the new priority in parallel, so push and pop take one pass.
//  Reset clears the entry count and both valid flags; entry contents are not reset.
//  A stalled result holds the result register and then the input register.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_stack_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [spsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // element, priority_req
  input  wire logic                             s_axis_tuser,  // op
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [spsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // top_element, top_priority,
                                                               // count, is_empty, error
);
  import spsc_pkg::*;

  logic              in_v_q;
  op_e               in_op_q;
  logic [ELEM_W-1:0] in_elem_q;
  logic [PRIO_W-1:0] in_prio_q;
  logic              out_v_q;
  res_t              out_res_q;
  res_t              res;
  logic              adv;
  logic              s_xfer;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  spsc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .op_i   (in_op_q),
    .elem_i (in_elem_q),
    .prio_i (in_prio_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_elem_q <= s_axis_tdata[ELEM_W-1:0];
      in_prio_q <= s_axis_tdata[ELEM_W +: PRIO_W];
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_res_q);

endmodule
`default_nettype wire

// ===== src/spsc_store.sv =====
// Sorted entry cells with parallel compare, shift insert and shift pop.
`timescale 1ns / 1ps
`default_nettype none
module spsc_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire spsc_pkg::op_e              op_i,
  input  wire logic [spsc_pkg::ELEM_W-1:0] elem_i,
  input  wire logic [spsc_pkg::PRIO_W-1:0] prio_i,
  output spsc_pkg::res_t                  res_o
);
  import spsc_pkg::*;

  logic [ELEM_W-1:0] elem_q [DEPTH];
  logic [ELEM_W-1:0] elem_d [DEPTH];
  logic [PRIO_W-1:0] prio_q [DEPTH];
  logic [PRIO_W-1:0] prio_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DEPTH-1:0]  keep;
  logic              full, empty;
  err_e              err;

  always_comb begin
    full  = (count_q == CNT_W'(DEPTH));
    empty = (count_q == '0);
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_q) && (prio_i < prio_q[i]);
    end
    elem_d  = elem_q;
    prio_d  = prio_q;
    count_d = count_q;
    err     = ERR_NONE;
    if (op_i == OP_PUSH) begin
      if (full) begin
        err = ERR_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (!keep[0]) begin
          elem_d[0] = elem_i;
          prio_d[0] = prio_i;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!keep[i]) begin
            if (keep[i-1]) begin
              elem_d[i] = elem_i;
              prio_d[i] = prio_i;
            end else begin
              elem_d[i] = elem_q[i-1];
              prio_d[i] = prio_q[i-1];
            end
          end
        end
      end
    end else begin
      if (empty) begin
        err = ERR_EMPTY;
      end else begin
        count_d = count_q - CNT_W'(1);
        for (int i = 0; i < DEPTH - 1; i++) begin
          elem_d[i] = elem_q[i+1];
          prio_d[i] = prio_q[i+1];
        end
      end
    end

    res_o.error    = err;
    res_o.count    = count_d;
    res_o.is_empty = (count_d == '0);
    if (count_d == '0) begin
      res_o.top_element  = '0;
      res_o.top_priority = '0;
    end else begin
      res_o.top_element  = elem_d[0];
      res_o.top_priority = prio_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elem_q <= elem_d;
      prio_q <= prio_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && op_i == OP_PUSH && full) |=> count_q == $past(count_q))
    else $error("push on full changed count");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && op_i == OP_POP && !empty) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(count_q))
    else $error("count moved without a transfer");

  a_front_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> prio_q[0] >= prio_q[1])
    else $error("front entries out of order");
`endif

endmodule
`default_nettype wire
